// ===== src/lcvs_pkg.sv =====
// shared types and constants for the led cube voxel store
`timescale 1ns / 1ps

package lcvs_pkg;

    localparam int COORD_W   = 3;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 3 * CHAN_W;
    localparam int LED_IDX_W = 6;

    localparam logic KIND_FILL    = 1'b0;
    localparam logic KIND_REFRESH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ
    } t_state;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] z_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [COORD_W-1:0] z_end;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0]   plane;
        logic [LED_IDX_W-1:0] led_index;
        logic [COLOR_W-1:0]   color_word;
        logic                 last;
    } t_rsp;

    typedef struct packed {
        logic [COORD_W-1:0]   plane;
        logic [LED_IDX_W-1:0] led_index;
        logic                 last;
    } t_tag;

endpackage

// ===== src/led_cube_voxel_store_core.sv =====
// top level of the led cube voxel store
//
// channel   direction  handshake                payload
// request   in         start high, busy low     i_req   (lcvs_pkg::t_req)
// result    out        o_strobe, one cycle      o_rsp   (lcvs_pkg::t_rsp)
//
// a fill writes every in-range voxel of the box, up to WIDTH**3
// a refresh reads WIDTH*WIDTH entries, each result comes out in the cycle after its read
// both run at one memory access per cycle on the single port
// out-of-range fills and planes return to idle at once
// reset clears all per-voxel valid bits at once, no clearing pass
// results cannot be held off by the receiver
`timescale 1ns / 1ps

module led_cube_voxel_store_core #(
    parameter int WIDTH = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lcvs_pkg::t_req i_req,
    output logic           o_strobe,
    output lcvs_pkg::t_rsp o_rsp
);

    localparam int CUBE   = WIDTH * WIDTH * WIDTH;
    localparam int ADDR_W = $clog2(CUBE);

    logic                         we, re;
    logic [ADDR_W-1:0]            addr;
    logic [lcvs_pkg::COLOR_W-1:0] wdata, rdata;
    lcvs_pkg::t_tag               tag;
    lcvs_pkg::t_tag               r_tag;
    logic                         r_strobe;

    lcvs_seq #(
        .WIDTH  (WIDTH),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .o_we    (we),
        .o_re    (re),
        .o_addr  (addr),
        .o_wdata (wdata),
        .o_tag   (tag)
    );

    lcvs_mem #(
        .DEPTH  (CUBE),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_re    (re),
        .i_addr  (addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= tag;
    end

    assign o_strobe         = r_strobe;
    assign o_rsp.plane      = r_tag.plane;
    assign o_rsp.led_index  = r_tag.led_index;
    assign o_rsp.color_word = rdata;
    assign o_rsp.last       = r_tag.last;

endmodule

// ===== src/lcvs_mem.sv =====
// voxel colour memory with per-entry valid bits cleared at reset
`timescale 1ns / 1ps

module lcvs_mem #(
    parameter int DEPTH  = 125,
    parameter int ADDR_W = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_addr,
    input  logic [lcvs_pkg::COLOR_W-1:0] i_wdata,
    output logic [lcvs_pkg::COLOR_W-1:0] o_rdata
);

    logic [lcvs_pkg::COLOR_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]             r_valid;
    logic [lcvs_pkg::COLOR_W-1:0] r_rdata;
    logic                         r_rok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
            r_rok   <= r_valid[i_addr];
        end
    end

    assign o_rdata = r_rok ? r_rdata : '0;

endmodule

// ===== src/lcvs_seq.sv =====
// sequencer and shared address unit for box fills and plane refreshes
`timescale 1ns / 1ps

module lcvs_seq #(
    parameter int WIDTH  = 5,
    parameter int ADDR_W = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  lcvs_pkg::t_req               i_req,
    output logic                         o_busy,
    output logic                         o_we,
    output logic                         o_re,
    output logic [ADDR_W-1:0]            o_addr,
    output logic [lcvs_pkg::COLOR_W-1:0] o_wdata,
    output lcvs_pkg::t_tag               o_tag
);

    localparam int PLANE = WIDTH * WIDTH;
    localparam int IDX_W = $clog2(PLANE);
    localparam logic [lcvs_pkg::COORD_W-1:0] W3 = lcvs_pkg::COORD_W'(WIDTH);

    lcvs_pkg::t_state r_state, n_state;

    logic [lcvs_pkg::COORD_W-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [lcvs_pkg::COORD_W-1:0] r_ylo, r_zlo, n_ylo, n_zlo;
    logic [lcvs_pkg::COORD_W-1:0] r_xhi, r_yhi, r_zhi, n_xhi, n_yhi, n_zhi;
    logic [lcvs_pkg::COORD_W-1:0] r_plane, n_plane;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [ADDR_W-1:0]            r_base, n_base;
    logic [lcvs_pkg::COLOR_W-1:0] r_color, n_color;

    logic [lcvs_pkg::COORD_W-1:0] xlo, ylo, zlo, xhi, yhi, zhi;
    logic                         box_ok, plane_ok, fill_done, read_done;
    logic [lcvs_pkg::COORD_W-1:0] mul_x;
    logic [ADDR_W-1:0]            plane_base, chain, op_a, op_b;
    logic [ADDR_W-1:0]            ye, ze;

    // clamp box to the cube
    always_comb begin
        xlo = (i_req.x_start == '0) ? lcvs_pkg::COORD_W'(1) : i_req.x_start;
        ylo = (i_req.y_start == '0) ? lcvs_pkg::COORD_W'(1) : i_req.y_start;
        zlo = (i_req.z_start == '0) ? lcvs_pkg::COORD_W'(1) : i_req.z_start;
        xhi = (i_req.x_end > W3) ? W3 : i_req.x_end;
        yhi = (i_req.y_end > W3) ? W3 : i_req.y_end;
        zhi = (i_req.z_end > W3) ? W3 : i_req.z_end;
        box_ok   = (xlo <= xhi) && (ylo <= yhi) && (zlo <= zhi);
        plane_ok = (i_req.x_start != '0) && (i_req.x_start <= W3);
    end

    // shared address unit
    always_comb begin
        mul_x      = (r_state == lcvs_pkg::ST_IDLE) ? i_req.x_start : r_x;
        plane_base = ADDR_W'(PLANE) * (ADDR_W'(mul_x) - ADDR_W'(1));
        ye = ADDR_W'(r_y);
        ze = ADDR_W'(r_z);
        if (r_z[0]) begin
            chain = ADDR_W'(WIDTH) * (ze - ADDR_W'(1)) + ye - ADDR_W'(1);
        end else begin
            chain = ADDR_W'(WIDTH) * ze - ye;
        end
        op_a   = (r_state == lcvs_pkg::ST_FILL) ? plane_base : r_base;
        op_b   = (r_state == lcvs_pkg::ST_FILL) ? chain : ADDR_W'(r_idx);
        o_addr = op_a + op_b;
    end

    assign fill_done = (r_z == r_zhi) && (r_y == r_yhi) && (r_x == r_xhi);
    assign read_done = (r_idx == IDX_W'(PLANE - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcvs_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_req.kind == lcvs_pkg::KIND_FILL && box_ok) begin
                        n_state = lcvs_pkg::ST_FILL;
                    end else if (i_req.kind == lcvs_pkg::KIND_REFRESH && plane_ok) begin
                        n_state = lcvs_pkg::ST_READ;
                    end
                end
            end
            lcvs_pkg::ST_FILL: begin
                if (fill_done) begin
                    n_state = lcvs_pkg::ST_IDLE;
                end
            end
            lcvs_pkg::ST_READ: begin
                if (read_done) begin
                    n_state = lcvs_pkg::ST_IDLE;
                end
            end
            default: n_state = lcvs_pkg::ST_IDLE;
        endcase
    end

    // counters and captured request
    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z;
        n_ylo = r_ylo; n_zlo = r_zlo;
        n_xhi = r_xhi; n_yhi = r_yhi; n_zhi = r_zhi;
        n_plane = r_plane; n_idx = r_idx; n_base = r_base; n_color = r_color;
        unique case (r_state)
            lcvs_pkg::ST_IDLE: begin
                n_x = xlo; n_y = ylo; n_z = zlo;
                n_ylo = ylo; n_zlo = zlo;
                n_xhi = xhi; n_yhi = yhi; n_zhi = zhi;
                n_plane = i_req.x_start;
                n_idx   = '0;
                n_base  = plane_base;
                n_color = {i_req.red_in, i_req.green_in, i_req.blue_in};
            end
            lcvs_pkg::ST_FILL: begin
                if (r_z != r_zhi) begin
                    n_z = r_z + lcvs_pkg::COORD_W'(1);
                end else begin
                    n_z = r_zlo;
                    if (r_y != r_yhi) begin
                        n_y = r_y + lcvs_pkg::COORD_W'(1);
                    end else begin
                        n_y = r_ylo;
                        n_x = r_x + lcvs_pkg::COORD_W'(1);
                    end
                end
            end
            lcvs_pkg::ST_READ: begin
                n_idx = r_idx + IDX_W'(1);
            end
            default: n_idx = r_idx;
        endcase
    end

    // outputs
    always_comb begin
        o_busy          = (r_state != lcvs_pkg::ST_IDLE);
        o_we            = (r_state == lcvs_pkg::ST_FILL);
        o_re            = (r_state == lcvs_pkg::ST_READ);
        o_wdata         = r_color;
        o_tag.plane     = r_plane;
        o_tag.led_index = lcvs_pkg::LED_IDX_W'(r_idx);
        o_tag.last      = read_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcvs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z;
        r_ylo <= n_ylo; r_zlo <= n_zlo;
        r_xhi <= n_xhi; r_yhi <= n_yhi; r_zhi <= n_zhi;
        r_plane <= n_plane;
        r_idx   <= n_idx;
        r_base  <= n_base;
        r_color <= n_color;
    end

endmodule

// ===== src/lcvs_check.sv =====
// port-level checks for the led cube voxel store, bound to the top level
`timescale 1ns / 1ps

module lcvs_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input lcvs_pkg::t_req i_req,
    input logic           o_strobe,
    input lcvs_pkg::t_rsp o_rsp
);

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a request in progress");

    a_plane_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_rsp.last |=> o_strobe)
        else $error("gap inside a plane refresh");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_rsp.last |=>
            o_rsp.led_index == lcvs_pkg::LED_IDX_W'($past(o_rsp.led_index) + 1'b1)
            && o_rsp.plane == $past(o_rsp.plane))
        else $error("led index or plane out of sequence");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.last |=> !o_strobe)
        else $error("result after last of plane");

    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !$past(o_strobe) |-> o_rsp.led_index == '0)
        else $error("refresh did not start at index zero");

endmodule

bind led_cube_voxel_store_core lcvs_check u_lcvs_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);
